[rtl/kqt_pkg.sv]
`timescale 1ns / 1ps

package kqt_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned QTY_W = 32;

  // action codes
  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_DUMP   = 2'd2;

  // result status codes
  localparam logic [3:0] ST_INSERTED     = 4'd0;
  localparam logic [3:0] ST_ACCUMULATED  = 4'd1;
  localparam logic [3:0] ST_NOT_FOUND    = 4'd2;
  localparam logic [3:0] ST_INSUFFICIENT = 4'd3;
  localparam logic [3:0] ST_REMOVED      = 4'd4;
  localparam logic [3:0] ST_FULL         = 4'd5;
  localparam logic [3:0] ST_ENTRY        = 4'd6;
  localparam logic [3:0] ST_EMPTY        = 4'd7;
  localparam logic [3:0] ST_SATURATED    = 4'd8;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic cmp;     // latch key match
    logic insert;  // load key and quantity into the target cell
    logic update;  // overwrite quantity of the matching cell
    logic shift;   // take contents of the neighbor cell
  } cell_ctrl_t;

endpackage

[rtl/kqt_cell.sv]
`timescale 1ns / 1ps

module kqt_cell import kqt_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cell_ctrl_t              ctrl_i,
  input  logic                    sel_i,
  input  logic                    active_i,
  input  logic signed [KEY_W-1:0] key_i,
  input  logic        [QTY_W-1:0] qty_i,
  input  logic signed [KEY_W-1:0] nbr_key_i,
  input  logic        [QTY_W-1:0] nbr_qty_i,
  output logic signed [KEY_W-1:0] key_o,
  output logic        [QTY_W-1:0] qty_o,
  output logic                    hit_o
);

  logic signed [KEY_W-1:0] key_q;
  logic        [QTY_W-1:0] qty_q;
  logic                    hit_q;

  // match flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (ctrl_i.cmp) begin
      hit_q <= active_i && (key_q == key_i);
    end
  end

  // entry contents, no reset
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      key_q <= nbr_key_i;
      qty_q <= nbr_qty_i;
    end else if (ctrl_i.insert && sel_i) begin
      key_q <= key_i;
      qty_q <= qty_i;
    end else if (ctrl_i.update && hit_q) begin
      qty_q <= qty_i;
    end
  end

  assign key_o = key_q;
  assign qty_o = qty_q;
  assign hit_o = hit_q;

endmodule

[rtl/keyed_quantity_table.sv]
`timescale 1ns / 1ps
// add or remove: accepted with the key compare, then the one-hot read, then the write-back
//   into the output register once it is free; the next command is accepted only after that
// dump: one entry per cycle from the head cell of the row, count_q entries (ST_EMPTY alone
//   if empty), paced by the output register
// reset clears the entry count and all handshake state; key and quantity cells are not cleared
module keyed_quantity_table import kqt_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              action_i,
  input  logic signed [KEY_W-1:0] item_key_i,
  input  logic        [QTY_W-1:0] amount_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [3:0]              status_o,
  output logic signed [KEY_W-1:0] entry_key_o,
  output logic        [QTY_W-1:0] entry_quantity_o,
  output logic                    last_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_DUMP = 2'd3;

  logic [1:0] state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] dcnt_q, dcnt_d;

  // latched command
  logic                    cmd_add_q;
  logic signed [KEY_W-1:0] cmd_key_q;
  logic        [QTY_W-1:0] cmd_amt_q;

  // one-hot read result
  logic             found_q;
  logic [QTY_W-1:0] old_q;

  // output register
  logic                    out_valid_q;
  logic [3:0]              status_q;
  logic signed [KEY_W-1:0] okey_q;
  logic        [QTY_W-1:0] oqty_q;
  logic                    last_q;

  // cell row
  cell_ctrl_t              ctrl;
  logic signed [KEY_W-1:0] bkey;
  logic        [QTY_W-1:0] bqty;
  logic signed [KEY_W-1:0] key_a [DEPTH];
  logic        [QTY_W-1:0] qty_a [DEPTH];
  logic [DEPTH-1:0]        hit;

  logic             accept;
  logic             slot_free;
  logic             emit;
  logic [3:0]       res_status;
  logic [QTY_W-1:0] res_qty;
  logic signed [KEY_W-1:0] res_key;
  logic             res_last;
  logic [QTY_W:0]   sum;
  logic             dump_last;
  logic [QTY_W-1:0] rd_qty;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  // key on the broadcast bus: incoming key for the compare at accept, latched key later
  assign bkey = (state_q == S_IDLE) ? item_key_i : cmd_key_q;

  // the row of cells; the cell at count_q-1 wraps to the head so a dump rotates
  // exactly the filled part and leaves it in insertion order after count_q shifts
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [KEY_W-1:0] nkey;
    logic        [QTY_W-1:0] nqty;
    if (i == DEPTH - 1) begin : g_tail
      assign nkey = key_a[0];
      assign nqty = qty_a[0];
    end else begin : g_mid
      assign nkey = (count_q == CW'(i + 1)) ? key_a[0] : key_a[i+1];
      assign nqty = (count_q == CW'(i + 1)) ? qty_a[0] : qty_a[i+1];
    end
    kqt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .sel_i     (count_q == CW'(i)),
      .active_i  (CW'(i) < count_q),
      .key_i     (bkey),
      .qty_i     (bqty),
      .nbr_key_i (nkey),
      .nbr_qty_i (nqty),
      .key_o     (key_a[i]),
      .qty_o     (qty_a[i]),
      .hit_o     (hit[i])
    );
  end

  // quantity of the matching cell, at most one hit since keys are unique
  always_comb begin
    rd_qty = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_qty = rd_qty | (hit[i] ? qty_a[i] : '0);
    end
  end

  assign sum       = {1'b0, old_q} + {1'b0, cmd_amt_q};
  assign dump_last = (dcnt_q == count_q - CW'(1));

  // result of the current step
  always_comb begin
    res_status = ST_ENTRY;
    res_key    = cmd_key_q;
    res_qty    = '0;
    res_last   = 1'b1;
    bqty       = cmd_amt_q;
    ctrl       = '0;
    count_d    = count_q;
    if (state_q == S_EXEC) begin
      if (cmd_add_q) begin
        if (found_q) begin
          if (sum[QTY_W]) begin
            res_status = ST_SATURATED;
            res_qty    = '1;
          end else begin
            res_status = ST_ACCUMULATED;
            res_qty    = sum[QTY_W-1:0];
          end
          ctrl.update = slot_free;
        end else if (count_q == CW'(DEPTH)) begin
          res_status = ST_FULL;
        end else begin
          res_status  = ST_INSERTED;
          res_qty     = cmd_amt_q;
          ctrl.insert = slot_free;
          if (slot_free) begin
            count_d = count_q + CW'(1);
          end
        end
      end else begin
        if (!found_q) begin
          res_status = ST_NOT_FOUND;
        end else if (cmd_amt_q > old_q) begin
          res_status = ST_INSUFFICIENT;
          res_qty    = old_q;
        end else begin
          res_status  = ST_REMOVED;
          res_qty     = old_q - cmd_amt_q;
          ctrl.update = slot_free;
        end
      end
      bqty = res_qty;
    end else if (state_q == S_DUMP) begin
      if (count_q == '0) begin
        res_status = ST_EMPTY;
        res_key    = '0;
      end else begin
        res_key    = key_a[0];
        res_qty    = qty_a[0];
        res_last   = dump_last;
        ctrl.shift = slot_free;
      end
    end
    // compare at accept for add and remove
    ctrl.cmp = accept && (action_i inside {ACT_ADD, ACT_REMOVE});
  end

  assign emit = slot_free && (state_q == S_EXEC || state_q == S_DUMP);

  // sequencer
  always_comb begin
    state_d = state_q;
    dcnt_d  = dcnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (action_i) inside
            ACT_ADD, ACT_REMOVE: state_d = S_READ;
            ACT_DUMP: begin
              state_d = S_DUMP;
              dcnt_d  = '0;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_READ: state_d = S_EXEC;
      S_EXEC: begin
        if (emit) begin
          state_d = S_IDLE;
        end
      end
      S_DUMP: begin
        if (emit) begin
          dcnt_d = dcnt_q + CW'(1);
          if (res_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      dcnt_q  <= dcnt_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_add_q <= (action_i == ACT_ADD);
      cmd_key_q <= item_key_i;
      cmd_amt_q <= amount_i;
    end
    if (state_q == S_READ) begin
      found_q <= |hit;
      old_q   <= rd_qty;
    end
    if (emit) begin
      status_q <= res_status;
      okey_q   <= res_key;
      oqty_q   <= res_qty;
      last_q   <= res_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign entry_key_o      = okey_q;
  assign entry_quantity_o = oqty_q;
  assign last_o           = last_q;

  // table never holds more than its depth
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  // keys are unique, so at most one cell matches
  a_hit_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> $onehot0(hit))
    else $error("several cells match one key");

  // the count only ever grows by one, and only on an insert
  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == $past(count_q) + CW'(1)
      && $past(ctrl.insert)))
    else $error("entry count changed without insert");

  // a dump leaves after its last transaction
  a_dump_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP && emit && res_last) |=> (state_q == S_IDLE))
    else $error("dump did not finish on last entry");

endmodule
